/* rtl/sh24_pkg.sv */
// Package with the SipHash-2-4 constants, types, sequencer states and round function.
package sh24_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned CountW = 4;
  localparam int unsigned LenW   = 8;
  localparam int unsigned IndexW = 8;

  localparam logic [WordW-1:0] SipC0 = 64'h736F6D6570736575;
  localparam logic [WordW-1:0] SipC1 = 64'h646F72616E646F6D;
  localparam logic [WordW-1:0] SipC2 = 64'h6C7967656E657261;
  localparam logic [WordW-1:0] SipC3 = 64'h7465646279746573;
  localparam logic [WordW-1:0] SipFinalXor = 64'h00000000000000FF;

  localparam logic [CountW-1:0] FullCount = 4'd8;

  localparam logic [IndexW-1:0] RegKeyLo = 8'd0;
  localparam logic [IndexW-1:0] RegKeyHi = 8'd1;

  typedef logic [3:0][WordW-1:0] sip_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_TAIL,
    ST_FIN,
    ST_FROUND,
    ST_OUT
  } seq_state_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (WordW - r));
  endfunction

  function automatic sip_state_t sip_round(input sip_state_t v);
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
    a = v[0];
    b = v[1];
    c = v[2];
    d = v[3];
    a = a + b;
    b = rotl(b, 13);
    b = b ^ a;
    a = rotl(a, 32);
    c = c + d;
    d = rotl(d, 16);
    d = d ^ c;
    a = a + d;
    d = rotl(d, 21);
    d = d ^ a;
    c = c + b;
    b = rotl(b, 17);
    b = b ^ c;
    c = rotl(c, 32);
    sip_round = {d, c, b, a};
  endfunction

  function automatic sip_state_t sip_init(input logic [WordW-1:0] k0,
                                          input logic [WordW-1:0] k1);
    sip_init = {SipC3 ^ k1, SipC2 ^ k0, SipC1 ^ k1, SipC0 ^ k0};
  endfunction

  function automatic logic [WordW-1:0] byte_mask(input logic [CountW-1:0] count);
    logic [WordW-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (CountW'(i) < count) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    byte_mask = m;
  endfunction

endpackage

/* rtl/sh24_msg_if.sv */
// Channel for message words with their byte count and last flag.
interface sh24_msg_if
  import sh24_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [WordW-1:0]  data_word;
  logic [CountW-1:0] byte_count;
  logic              last;

  modport source (output valid, output data_word, output byte_count, output last, input ready);
  modport sink (input valid, input data_word, input byte_count, input last, output ready);
endinterface

/* rtl/sh24_res_if.sv */
// Channel for digest results with their error flag.
interface sh24_res_if
  import sh24_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] digest;
  logic             error;

  modport source (output valid, output digest, output error, input ready);
  modport sink (input valid, input digest, input error, output ready);
endinterface

/* rtl/sh24_cfg_if.sv */
// Channel for configuration register writes.
interface sh24_cfg_if
  import sh24_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [IndexW-1:0] index;
  logic [WordW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/siphash_2_4_keyed_hash.sv */
// Keyed SipHash-2-4 hash engine with one shared round unit under a small sequencer.
//
//   channel  dir  contents                          handshake
//   msg      in   data_word, byte_count, last       valid/ready
//   res      out  digest, error                     valid/ready
//   cfg      in   index, data (key halves)          valid/ready
//
// One SipRound per cycle runs in the single round unit in ST_COMP and ST_FROUND.
// A full non-last word is accepted in ST_IDLE, then gets two rounds in ST_COMP.
// A last word also passes ST_FIN and four ST_FROUND rounds; ST_OUT registers it.
// Reset and every key write reload the state from the key; cfg is always ready.
// A result waiting on res holds the engine in its output state until taken.
module siphash_2_4_keyed_hash
  import sh24_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  sh24_msg_if.sink    msg,
  sh24_res_if.source  res,
  sh24_cfg_if.sink    cfg
);

  seq_state_t        state, state_next;
  sip_state_t        v, v_next;
  logic [WordW-1:0]  key_lo, key_lo_next;
  logic [WordW-1:0]  key_hi, key_hi_next;
  logic [WordW-1:0]  m, m_next;
  logic [LenW-1:0]   len, len_next;
  logic [1:0]        rnd, rnd_next;
  logic              tail_pend, tail_pend_next;
  logic              err, err_next;
  logic              res_valid, res_valid_next;
  logic [WordW-1:0]  res_digest, res_digest_next;
  logic              res_error, res_error_next;
  logic              final_flag, final_flag_next;

  sip_state_t        v_round;
  logic [CountW-1:0] count;
  logic [WordW-1:0]  tail;
  logic [LenW-1:0]   len_tail;
  logic              msg_fire;
  logic              cfg_fire;

  assign v_round   = sip_round(v);
  assign count     = (msg.byte_count > FullCount) ? FullCount : msg.byte_count;
  assign len_tail  = len + LenW'(count);
  assign tail      = (msg.data_word & byte_mask(count)) | {len_tail, {(WordW-LenW){1'b0}}};
  assign msg_fire  = msg.valid && msg.ready;
  assign cfg_fire  = cfg.valid && cfg.ready;

  assign msg.ready  = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;
  assign res.valid  = res_valid;
  assign res.digest = res_digest;
  assign res.error  = res_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      key_lo    <= '0;
      key_hi    <= '0;
      v         <= sip_init('0, '0);
      len       <= '0;
      rnd       <= '0;
      tail_pend <= 1'b0;
      err       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      key_lo    <= key_lo_next;
      key_hi    <= key_hi_next;
      v         <= v_next;
      len       <= len_next;
      rnd       <= rnd_next;
      tail_pend <= tail_pend_next;
      err       <= err_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    m          <= m_next;
    res_digest <= res_digest_next;
    res_error  <= res_error_next;
  end

  always_comb begin
    state_next      = state;
    key_lo_next     = key_lo;
    key_hi_next     = key_hi;
    v_next          = v;
    m_next          = m;
    len_next        = len;
    rnd_next        = rnd;
    tail_pend_next  = tail_pend;
    err_next        = err;
    res_valid_next  = res_valid;
    res_digest_next = res_digest;
    res_error_next  = res_error;

    if (res_valid && res.ready) begin
      res_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (msg_fire) begin
          rnd_next = '0;
          if (count == FullCount) begin
            v_next[3]      = v[3] ^ msg.data_word;
            m_next         = msg.data_word;
            len_next       = len + LenW'(FullCount);
            tail_pend_next = msg.last;
            err_next       = 1'b0;
            state_next     = ST_COMP;
          end else if (msg.last) begin
            v_next[3]      = v[3] ^ tail;
            m_next         = tail;
            len_next       = len_tail;
            tail_pend_next = 1'b0;
            err_next       = 1'b0;
            state_next     = ST_COMP;
          end else begin
            err_next   = 1'b1;
            state_next = ST_OUT;
          end
        end
      end
      ST_COMP: begin
        v_next   = v_round;
        rnd_next = rnd + 2'd1;
        if (rnd == 2'd1) begin
          v_next[0] = v_round[0] ^ m;
          rnd_next  = '0;
          if (tail_pend) begin
            state_next = ST_TAIL;
          end else if (final_flag) begin
            state_next = ST_FIN;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        v_next[3]      = v[3] ^ {len, {(WordW-LenW){1'b0}}};
        m_next         = {len, {(WordW-LenW){1'b0}}};
        tail_pend_next = 1'b0;
        err_next       = 1'b0;
        state_next     = ST_COMP;
      end
      ST_FIN: begin
        v_next[2]  = v[2] ^ SipFinalXor;
        rnd_next   = '0;
        state_next = ST_FROUND;
      end
      ST_FROUND: begin
        v_next   = v_round;
        rnd_next = rnd + 2'd1;
        if (rnd == 2'd3) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!res_valid || res.ready) begin
          res_valid_next  = 1'b1;
          res_error_next  = err;
          res_digest_next = err ? '0 : (v[0] ^ v[1] ^ v[2] ^ v[3]);
          v_next          = sip_init(key_lo, key_hi);
          len_next        = '0;
          err_next        = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (cfg_fire && (cfg.index == RegKeyLo || cfg.index == RegKeyHi)) begin
      if (cfg.index == RegKeyLo) begin
        key_lo_next = cfg.data;
      end else begin
        key_hi_next = cfg.data;
      end
      v_next         = sip_init(key_lo_next, key_hi_next);
      len_next       = '0;
      tail_pend_next = 1'b0;
      err_next       = 1'b0;
      state_next     = ST_IDLE;
    end
  end

  // The final flag marks a compression whose word closed the message.
  always_ff @(posedge clk) begin
    if (rst) begin
      final_flag <= 1'b0;
    end else begin
      final_flag <= final_flag_next;
    end
  end

  always_comb begin
    final_flag_next = final_flag;
    if (state == ST_IDLE && msg_fire) begin
      final_flag_next = msg.last;
    end
    if (cfg_fire) begin
      final_flag_next = 1'b0;
    end
  end

endmodule

/* test/tb.sv */
// Self-checking testbench for the SipHash-2-4 engine: known vectors, then random messages.
`timescale 1ns / 1ps

module tb;
  import sh24_pkg::*;

  localparam int ResetCycles  = 8;
  localparam int SettleCycles = 20;
  localparam int CycleLimit   = 400000;
  localparam int PhaseWords   = 315;
  localparam int PhaseCount   = 6;
  localparam int MaxReports   = 10;

  localparam logic [IndexW-1:0] RegPastEnd = 8'd2;
  localparam logic [IndexW-1:0] RegTop     = 8'hFF;
  localparam logic [WordW-1:0]  AllOnes    = '1;

  typedef struct packed {
    logic [WordW-1:0] digest;
    logic             error;
  } digest_res_t;

  typedef enum logic {RowWord, RowKey} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [IndexW-1:0] index;
    logic [WordW-1:0]  data;
    logic [CountW-1:0] count;
    logic              last;
    bit                typed;
    digest_res_t       want;
  } vector_row_t;

  logic clk;
  logic rst;

  sh24_msg_if msg ();
  sh24_res_if res ();
  sh24_cfg_if cfg ();

  siphash_2_4_keyed_hash u_top (
    .clk (clk),
    .rst (rst),
    .msg (msg),
    .res (res),
    .cfg (cfg)
  );

  logic [WordW-1:0] key_lo;
  logic [WordW-1:0] key_hi;
  logic [WordW-1:0] sip_v [4];
  logic [LenW-1:0]  msg_len;
  digest_res_t      digest_q [$];
  vector_row_t      directed [$];

  int cycle_count;
  int mismatches;
  int words_sent;
  int digests_seen;
  int discards_seen;
  int reg_writes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d digests outstanding", cycle_count, digest_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [WordW-1:0] rol(input logic [WordW-1:0] x, input int r);
    return (x << r) | (x >> (WordW - r));
  endfunction

  function automatic void sip_mix();
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
    a = sip_v[0];
    b = sip_v[1];
    c = sip_v[2];
    d = sip_v[3];
    a = a + b;
    b = rol(b, 13) ^ a;
    a = rol(a, 32);
    c = c + d;
    d = rol(d, 16) ^ c;
    a = a + d;
    d = rol(d, 21) ^ a;
    c = c + b;
    b = rol(b, 17) ^ c;
    c = rol(c, 32);
    sip_v[0] = a;
    sip_v[1] = b;
    sip_v[2] = c;
    sip_v[3] = d;
  endfunction

  function automatic void reload_key();
    sip_v[0] = SipC0 ^ key_lo;
    sip_v[1] = SipC1 ^ key_hi;
    sip_v[2] = SipC2 ^ key_lo;
    sip_v[3] = SipC3 ^ key_hi;
    msg_len  = '0;
  endfunction

  function automatic void absorb(input logic [WordW-1:0] m);
    sip_v[3] = sip_v[3] ^ m;
    sip_mix();
    sip_mix();
    sip_v[0] = sip_v[0] ^ m;
  endfunction

  // Advances the hash state by one word and tells whether the word closes a message.
  function automatic void hash_word(input logic [WordW-1:0] data, input logic [CountW-1:0] count,
                                    input logic last, output bit made, output digest_res_t r);
    logic [CountW-1:0] n;
    logic [WordW-1:0]  tail;
    n    = (count > FullCount) ? FullCount : count;
    made = 1'b0;
    r    = '0;
    if (!last) begin
      if (n < FullCount) begin
        made    = 1'b1;
        r.error = 1'b1;
        reload_key();
      end else begin
        absorb(data);
        msg_len = msg_len + LenW'(8);
      end
      return;
    end
    if (n == FullCount) begin
      absorb(data);
      msg_len = msg_len + LenW'(8);
      tail    = '0;
    end else begin
      tail    = data & ((64'd1 << (8 * n)) - 64'd1);
      msg_len = msg_len + LenW'(n);
    end
    tail[63:56] = msg_len;
    absorb(tail);
    sip_v[2] = sip_v[2] ^ SipFinalXor;
    for (int i = 0; i < 4; i++) begin
      sip_mix();
    end
    made     = 1'b1;
    r.digest = sip_v[0] ^ sip_v[1] ^ sip_v[2] ^ sip_v[3];
    reload_key();
  endfunction

  function automatic int draw_gap(input bit calm);
    int g;
    g = $urandom_range(0, 19);
    return calm ? 0 : g;
  endfunction

  function automatic logic [WordW-1:0] rand_word();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return AllOnes;
    return {$urandom, $urandom};
  endfunction

  function automatic vector_row_t word_row(input logic [WordW-1:0] data,
                                           input logic [CountW-1:0] count, input logic last);
    vector_row_t row;
    row = '{kind: RowWord, index: '0, data: data, count: count, last: last, typed: 1'b0,
            want: '0};
    return row;
  endfunction

  function automatic vector_row_t checked_row(input logic [WordW-1:0] data,
                                              input logic [CountW-1:0] count, input logic last,
                                              input logic [WordW-1:0] digest, input logic error);
    vector_row_t row;
    row        = word_row(data, count, last);
    row.typed  = 1'b1;
    row.want   = '{digest: digest, error: error};
    return row;
  endfunction

  function automatic vector_row_t key_row(input logic [IndexW-1:0] idx,
                                          input logic [WordW-1:0] value);
    vector_row_t row;
    row       = word_row(value, '0, 1'b0);
    row.kind  = RowKey;
    row.index = idx;
    return row;
  endfunction

  task automatic report(input string what, input digest_res_t want, input digest_res_t got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("mismatch (%s): expected digest %h error %b, got digest %h error %b",
               what, want.digest, want.error, got.digest, got.error);
    end
  endtask

  task automatic send_word(input logic [WordW-1:0] data, input logic [CountW-1:0] count,
                           input logic last, input bit typed, input digest_res_t want);
    int          gap;
    bit          made;
    digest_res_t r;
    gap = draw_gap((cycle_count % 2000) < 400);
    if (gap > 0) begin
      msg.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg.valid      <= 1'b1;
    msg.data_word  <= data;
    msg.byte_count <= count;
    msg.last       <= last;
    do @(posedge clk); while (!msg.ready);
    hash_word(data, count, last, made, r);
    if (made) begin
      digest_q.push_back(typed ? want : r);
    end
    words_sent++;
  endtask

  task automatic write_reg(input logic [IndexW-1:0] idx, input logic [WordW-1:0] value,
                           input bit more);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    if (!more) begin
      cfg.valid <= 1'b0;
    end
    if (idx == RegKeyLo) begin
      key_lo = value;
      reload_key();
    end else if (idx == RegKeyHi) begin
      key_hi = value;
      reload_key();
    end
    reg_writes++;
  endtask

  task automatic wait_idle();
    msg.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    int          gap;
    digest_res_t want;
    digest_res_t got;
    res.ready <= 1'b0;
    repeat (ResetCycles) @(posedge clk);
    forever begin
      gap = draw_gap(((cycle_count + 900) % 1700) < 350);
      if (gap > 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
      got = '{digest: res.digest, error: res.error};
      if (got.error) discards_seen++;
      else digests_seen++;
      if (digest_q.size() == 0) begin
        report("no digest expected", '0, got);
      end else begin
        want = digest_q.pop_front();
        if (got.digest !== want.digest) report("digest", want, got);
        else if (got.error !== want.error) report("error flag", want, got);
      end
    end
  end

  initial begin
    int                nfull;
    int                break_at;
    int                start;
    int                kind;
    bit                broken;
    logic [CountW-1:0] cnt;
    logic [WordW-1:0]  lo;
    logic [WordW-1:0]  hi;

    rst            <= 1'b1;
    msg.valid      <= 1'b0;
    msg.data_word  <= '0;
    msg.byte_count <= '0;
    msg.last       <= 1'b0;
    cfg.valid      <= 1'b0;
    cfg.index      <= '0;
    cfg.data       <= '0;
    key_lo = '0;
    key_hi = '0;
    reload_key();
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // Zero key from reset: empty message, full and saturated counts, short non-last words.
    directed.push_back(word_row(AllOnes, 4'd0, 1'b1));
    directed.push_back(word_row(AllOnes, FullCount, 1'b1));
    directed.push_back(word_row(64'h0123456789ABCDEF, 4'd15, 1'b0));
    directed.push_back(word_row(AllOnes, 4'd9, 1'b1));
    directed.push_back(checked_row(AllOnes, 4'd7, 1'b0, '0, 1'b1));
    directed.push_back(checked_row('0, 4'd0, 1'b0, '0, 1'b1));
    directed.push_back(checked_row(64'hA5A5A5A5A5A5A5A5, 4'd3, 1'b0, '0, 1'b1));
    directed.push_back(word_row(AllOnes, 4'd1, 1'b1));
    directed.push_back(word_row(AllOnes, 4'd7, 1'b1));
    // Published vectors for the key 00 01 .. 0F, with junk above the byte count.
    directed.push_back(key_row(RegKeyLo, 64'h0706050403020100));
    directed.push_back(key_row(RegKeyHi, 64'h0F0E0D0C0B0A0908));
    directed.push_back(checked_row(AllOnes, 4'd0, 1'b1, 64'h726FDB47DD0E0E31, 1'b0));
    directed.push_back(word_row(64'h0706050403020100, FullCount, 1'b0));
    directed.push_back(checked_row(64'hFF0E0D0C0B0A0908, 4'd7, 1'b1, 64'hA129CA6149BE45E5, 1'b0));
    // A write to an unused index leaves the open message alone; a key write drops it.
    directed.push_back(word_row('0, FullCount, 1'b0));
    directed.push_back(key_row(RegPastEnd, AllOnes));
    directed.push_back(word_row(64'h00000000DEADBEEF, 4'd4, 1'b1));
    directed.push_back(word_row(64'h5555555555555555, FullCount, 1'b0));
    directed.push_back(key_row(RegKeyHi, AllOnes));
    directed.push_back(word_row('0, FullCount, 1'b1));
    directed.push_back(key_row(RegKeyLo, AllOnes));
    directed.push_back(word_row(AllOnes, FullCount, 1'b0));
    directed.push_back(word_row(AllOnes, 4'd2, 1'b1));
    directed.push_back(key_row(RegTop, '0));
    directed.push_back(word_row('0, 4'd0, 1'b1));

    foreach (directed[i]) begin
      if (directed[i].kind == RowKey) begin
        wait_idle();
        write_reg(directed[i].index, directed[i].data, 1'b0);
      end else begin
        send_word(directed[i].data, directed[i].count, directed[i].last, directed[i].typed,
                  directed[i].want);
      end
    end

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end
        1: begin
          lo = '0;
          hi = '0;
        end
        2: begin
          lo = AllOnes;
          hi = AllOnes;
        end
        3: begin
          lo = AllOnes;
          hi = '0;
        end
        4: begin
          lo = '0;
          hi = AllOnes;
        end
        default: begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end
      endcase
      wait_idle();
      if ($urandom_range(0, 2) == 0) begin
        write_reg(($urandom_range(0, 1) == 0) ? RegPastEnd : RegTop, {$urandom, $urandom}, 1'b1);
      end
      if ($urandom_range(0, 1) == 0) begin
        write_reg(RegKeyLo, lo, 1'b1);
        write_reg(RegKeyHi, hi, 1'b0);
      end else begin
        write_reg(RegKeyHi, hi, 1'b1);
        write_reg(RegKeyLo, lo, 1'b0);
      end

      start = words_sent;
      while (words_sent - start < PhaseWords) begin
        kind     = $urandom_range(0, 9);
        nfull    = (kind == 0) ? $urandom_range(30, 40) : $urandom_range(0, 5);
        broken   = (kind == 1);
        break_at = $urandom_range(0, nfull);
        for (int w = 0; w <= nfull; w++) begin
          if (broken && w == break_at) begin
            send_word(rand_word(), 4'($urandom_range(0, 7)), 1'b0, 1'b0, '0);
            break;
          end
          if (w == nfull) begin
            cnt = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
            send_word(rand_word(), cnt, 1'b1, 1'b0, '0);
          end else begin
            cnt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : FullCount;
            send_word(rand_word(), cnt, 1'b0, 1'b0, '0);
          end
        end
      end
    end

    wait_idle();
    $display("run covered %0d message words and %0d register writes over %0d key settings",
             words_sent, reg_writes, PhaseCount + 4);
    $display("%0d digests and %0d discarded messages checked, %0d mismatches",
             digests_seen, discards_seen, mismatches);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sh24_pkg.sv
rtl/sh24_msg_if.sv
rtl/sh24_res_if.sv
rtl/sh24_cfg_if.sv
rtl/siphash_2_4_keyed_hash.sv
test/tb.sv
